FILE: rtl/evcs_pkg.sv
// ----------------------------------------------------------------------------
// evcs_pkg
// Types and constants shared by the edge voxel corner stepper and its checker.
// ----------------------------------------------------------------------------
package evcs_pkg;

   // Reset value of the voxel size register.
   localparam logic [7:0] VOXEL_SIZE_RESET = 8'd1;

   // Default bound on the voxel count of one edge.
   localparam int MAX_VOXELS_DEFAULT = 32;

   // One edge: two endpoints in signed Q16.8.
   typedef struct packed {
      logic signed [23:0] start_x;
      logic signed [23:0] start_y;
      logic signed [23:0] start_z;
      logic signed [23:0] end_x;
      logic signed [23:0] end_y;
      logic signed [23:0] end_z;
   } req_type;

   // One snapped voxel corner.
   typedef struct packed {
      logic signed [15:0] corner_x;
      logic signed [15:0] corner_y;
      logic signed [15:0] corner_z;
      logic               last_corner;
   } rsp_type;

endpackage

FILE: rtl/edge_voxel_corner_stepper_unit.sv
// ----------------------------------------------------------------------------
// edge_voxel_corner_stepper_unit
// Walks one triangle edge in half-voxel steps and emits snapped voxel corners.
// ----------------------------------------------------------------------------
// An edge is taken only while the unit is idle; it then holds req_stall high
// until the last corner of the edge has been loaded into the output register.
// An edge passes through three multiplies and an accumulate (squared length),
// a square root, the voxel count n (at most MAX_VOXELS_PER_EDGE), a set-up
// step and nine divisions; the square root, the count and the divisions share
// one 52-bit subtractor. Then 2n corners follow (one corner per cycle while
// rsp_stall is low). An edge shorter than one voxel produces no corner and
// returns the unit to idle after the count.
module edge_voxel_corner_stepper_unit
   import evcs_pkg::*;
#(
   parameter int MAX_VOXELS_PER_EDGE = MAX_VOXELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int CW = $clog2(MAX_VOXELS_PER_EDGE + 1);
   localparam int SW = CW + 1;
   localparam int DW = CW + 9;
   localparam logic [CW-1:0] MAX_N = CW'(MAX_VOXELS_PER_EDGE);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_MULL  = 4'd2;
   localparam logic [3:0] ST_SQRT  = 4'd3;
   localparam logic [3:0] ST_CNT   = 4'd4;
   localparam logic [3:0] ST_INIT  = 4'd5;
   localparam logic [3:0] ST_DLOAD = 4'd6;
   localparam logic [3:0] ST_DRUN  = 4'd7;
   localparam logic [3:0] ST_DFIN  = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   localparam logic [1:0] KIND_STEP = 2'd0;
   localparam logic [1:0] KIND_BASE = 2'd1;
   localparam logic [1:0] KIND_STEPMOD = 2'd2;

   logic [3:0]         state_ff, state_in;
   logic [7:0]         vs_ff;
   logic [7:0]         vs_eff;
   logic signed [23:0] s_ff [3];
   logic signed [24:0] d_ff [3];
   logic [1:0]         crd_ff, kind_ff;
   logic [49:0]        prod_ff, sum_ff;
   logic signed [49:0] sq_w;
   logic [50:0]        res_ff, bit_ff, res_nx;
   logic [24:0]        acc_ff;
   logic [CW-1:0]      n_ff;
   logic [SW-1:0]      steps, k_ff;
   logic [DW-1:0]      den;
   logic [15:0]        du_ff, dq_ff;
   logic [7:0]         dr_ff, dy_ff;
   logic               dneg_ff;
   logic [3:0]         dcnt_ff;
   logic [15:0]        div_x, div_q;
   logic [7:0]         div_y, div_r;
   logic signed [15:0] q_ff [3];
   logic signed [15:0] qd_ff [3];
   logic [CW-1:0]      rh_ff [3];
   logic [7:0]         m_ff [3];
   logic [7:0]         qdm_ff [3];
   logic [DW-1:0]      r_ff [3];
   logic [DW-1:0]      r_nx [3];
   logic [15:0]        q_nx [3];
   logic [7:0]         m_nx [3];
   logic [15:0]        corner [3];
   logic [51:0]        alu_a, alu_b;
   logic [52:0]        alu_diff;
   logic               alu_ge;
   logic               out_free, last_k;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // Snap a floored coordinate toward zero onto the voxel grid, given its
   // floor remainder m modulo the voxel size.
   function automatic logic [15:0] snap_corner(logic [15:0] q, logic [7:0] m,
                                               logic [7:0] vs);
      logic [16:0] qe;
      logic [16:0] mag;
      logic [16:0] r;
      qe  = {q[15], q};
      mag = q[15] ? (17'd0 - qe) : qe;
      if (mag <= {9'd0, vs}) begin
         r = 17'd0;
      end else if (!q[15]) begin
         r = qe - {9'd0, m};
      end else if (m == 8'd0) begin
         r = qe;
      end else begin
         r = qe - {9'd0, m} + {9'd0, vs};
      end
      return r[15:0];
   endfunction

   assign vs_eff    = (vs_ff == 8'd0) ? 8'd1 : vs_ff;
   assign steps     = {n_ff, 1'b0};
   assign den       = {n_ff, 9'd0};
   assign sq_w      = d_ff[crd_ff] * d_ff[crd_ff];
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_k    = (k_ff == steps - SW'(1));

   // Shared subtractor: square root trial, voxel count and division steps.
   always_comb begin
      alu_a = 52'd0;
      alu_b = 52'd0;
      unique case (state_ff)
         ST_SQRT: begin
            alu_a = 52'(sum_ff);
            alu_b = 52'(res_ff) + 52'(bit_ff);
         end
         ST_CNT: begin
            alu_a = 52'(acc_ff);
            alu_b = 52'({vs_eff, 8'd0});
         end
         ST_DRUN: begin
            alu_a = 52'({dr_ff, du_ff[15]});
            alu_b = 52'(dy_ff);
         end
         default: begin
            alu_a = 52'd0;
            alu_b = 52'd0;
         end
      endcase
      alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
      alu_ge   = !alu_diff[52];
   end

   assign res_nx = alu_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   // Dividend and divisor of the current division job.
   always_comb begin
      case (kind_ff)
         KIND_STEP: begin
            div_x = d_ff[crd_ff][24:9];
            div_y = 8'(n_ff);
         end
         KIND_BASE: begin
            div_x = s_ff[crd_ff][23:8];
            div_y = vs_eff;
         end
         KIND_STEPMOD: begin
            div_x = qd_ff[crd_ff];
            div_y = vs_eff;
         end
         default: begin
            div_x = 16'd0;
            div_y = vs_eff;
         end
      endcase
   end

   // Turn the magnitude quotient and remainder into floor form.
   always_comb begin
      if (!dneg_ff) begin
         div_q = dq_ff;
         div_r = dr_ff;
      end else if (dr_ff == 8'd0) begin
         div_q = 16'd0 - dq_ff;
         div_r = 8'd0;
      end else begin
         div_q = ~dq_ff;
         div_r = dy_ff - dr_ff;
      end
   end

   // Corner of the current sample and the step to the next one.
   always_comb begin
      logic [DW:0] r2;
      logic        cy;
      logic [8:0]  m2;
      for (int c = 0; c < 3; c++) begin
         corner[c] = snap_corner(q_ff[c], m_ff[c], vs_eff);
         r2 = {1'b0, r_ff[c]} + {1'b0, rh_ff[c], d_ff[c][8:0]};
         cy = (r2 >= {1'b0, den});
         r_nx[c] = cy ? DW'(r2 - {1'b0, den}) : DW'(r2);
         q_nx[c] = q_ff[c] + qd_ff[c] + 16'(cy);
         m2 = {1'b0, m_ff[c]} + {1'b0, qdm_ff[c]} + 9'(cy);
         m_nx[c] = (m2 >= {1'b0, vs_eff}) ? 8'(m2 - {1'b0, vs_eff}) : m2[7:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL;
         ST_MUL:   if (crd_ff == 2'd2) state_in = ST_MULL;
         ST_MULL:  state_in = ST_SQRT;
         ST_SQRT:  if (bit_ff == 51'd1) state_in = ST_CNT;
         ST_CNT: begin
            if (n_ff == MAX_N || !alu_ge) begin
               state_in = (n_ff == '0) ? ST_IDLE : ST_INIT;
            end
         end
         ST_INIT:  state_in = ST_DLOAD;
         ST_DLOAD: state_in = ST_DRUN;
         ST_DRUN:  if (dcnt_ff == 4'd15) state_in = ST_DFIN;
         ST_DFIN: begin
            if (crd_ff == 2'd2 && kind_ff == KIND_STEPMOD) state_in = ST_OUT;
            else state_in = ST_DLOAD;
         end
         ST_OUT:   if (out_free && last_k) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vs_ff        <= VOXEL_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
         crd_ff       <= 2'd0;
         kind_ff      <= KIND_STEP;
         n_ff         <= '0;
         k_ff         <= '0;
         dcnt_ff      <= 4'd0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) vs_ff <= csr_wr_data;

         // The output register is loaded in the output state and emptied by
         // a transfer.
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  s_ff[0] <= req_data.start_x;
                  s_ff[1] <= req_data.start_y;
                  s_ff[2] <= req_data.start_z;
                  d_ff[0] <= {req_data.end_x[23], req_data.end_x}
                           - {req_data.start_x[23], req_data.start_x};
                  d_ff[1] <= {req_data.end_y[23], req_data.end_y}
                           - {req_data.start_y[23], req_data.start_y};
                  d_ff[2] <= {req_data.end_z[23], req_data.end_z}
                           - {req_data.start_z[23], req_data.start_z};
                  crd_ff  <= 2'd0;
                  n_ff    <= '0;
                  sum_ff  <= 50'd0;
               end
            end
            ST_MUL: begin
               prod_ff <= sq_w;
               if (crd_ff != 2'd0) sum_ff <= sum_ff + prod_ff;
               crd_ff <= (crd_ff == 2'd2) ? 2'd0 : crd_ff + 2'd1;
            end
            ST_MULL: begin
               sum_ff <= sum_ff + prod_ff;
               res_ff <= 51'd0;
               bit_ff <= {1'b1, 50'd0};
            end
            ST_SQRT: begin
               if (alu_ge) sum_ff <= alu_diff[49:0];
               res_ff <= res_nx;
               bit_ff <= bit_ff >> 2;
               acc_ff <= res_nx[24:0];
            end
            ST_CNT: begin
               if (!(n_ff == MAX_N || !alu_ge)) begin
                  acc_ff <= alu_diff[24:0];
                  n_ff   <= n_ff + CW'(1);
               end
            end
            ST_INIT: begin
               for (int c = 0; c < 3; c++) begin
                  r_ff[c] <= DW'(s_ff[c][7:0]) * DW'(steps);
                  q_ff[c] <= s_ff[c][23:8];
               end
               k_ff    <= '0;
               kind_ff <= KIND_STEP;
               crd_ff  <= 2'd0;
            end
            ST_DLOAD: begin
               dneg_ff <= div_x[15];
               du_ff   <= div_x[15] ? (16'd0 - div_x) : div_x;
               dy_ff   <= div_y;
               dr_ff   <= 8'd0;
               dq_ff   <= 16'd0;
               dcnt_ff <= 4'd0;
            end
            ST_DRUN: begin
               dr_ff   <= alu_ge ? alu_diff[7:0] : alu_a[7:0];
               du_ff   <= du_ff << 1;
               dq_ff   <= {dq_ff[14:0], alu_ge};
               dcnt_ff <= dcnt_ff + 4'd1;
            end
            ST_DFIN: begin
               case (kind_ff)
                  KIND_STEP: begin
                     qd_ff[crd_ff] <= div_q;
                     rh_ff[crd_ff] <= CW'(div_r);
                  end
                  KIND_BASE:    m_ff[crd_ff]   <= div_r;
                  KIND_STEPMOD: qdm_ff[crd_ff] <= div_r;
                  default:      qdm_ff[crd_ff] <= div_r;
               endcase
               if (crd_ff == 2'd2) begin
                  crd_ff  <= 2'd0;
                  kind_ff <= kind_ff + 2'd1;
               end else begin
                  crd_ff <= crd_ff + 2'd1;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_data_ff.corner_x    <= corner[0];
                  rsp_data_ff.corner_y    <= corner[1];
                  rsp_data_ff.corner_z    <= corner[2];
                  rsp_data_ff.last_corner <= last_k;
                  for (int c = 0; c < 3; c++) begin
                     r_ff[c] <= r_nx[c];
                     q_ff[c] <= q_nx[c];
                     m_ff[c] <= m_nx[c];
                  end
                  k_ff <= k_ff + SW'(1);
               end
            end
            default: begin
               crd_ff <= 2'd0;
            end
         endcase
      end
   end

endmodule

FILE: rtl/evcs_checker.sv
// ----------------------------------------------------------------------------
// evcs_checker
// Port-level checks of the edge voxel corner stepper, bound to the top level.
// ----------------------------------------------------------------------------
module evcs_checker
   import evcs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input req_type    req_data,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input rsp_type    rsp_data,
   input logic       csr_wr_en,
   input logic [7:0] csr_wr_data
);

   // A stalled corner holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled corner changed");

   // An accepted edge keeps the unit busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("unit not busy after accepting an edge");

   // While a corner that is not the last one waits, the edge is still in work.
   a_busy_mid_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_corner |-> req_stall)
      else $error("unit idle with corners of the edge still to come");

   // Out of reset the unit is idle with no corner pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("unit not idle after reset");

endmodule

bind edge_voxel_corner_stepper_unit evcs_checker u_evcs_checker (.*);

FILE: tb/tb_edge_voxel_corner_stepper_unit.sv
// ----------------------------------------------------------------------------
// tb_edge_voxel_corner_stepper_unit
// Self-checking bench for the edge voxel corner stepper. Edges are driven over
// a valid/stall channel and every snapped corner is compared with a corner
// list worked out in the bench. The run covers several voxel sizes, idling on
// both sides, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_edge_voxel_corner_stepper_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import evcs_pkg::*;

   localparam int MAX_VOX = 32;
   localparam int SETTLE  = 400;

   // Corner list store: predicts the corners of each accepted edge.
   class corner_board;
      rsp_type    pending_q[$];
      logic [7:0] vox_size = VOXEL_SIZE_RESET;
      int         mismatches = 0;

      // Integer square root, bit by bit.
      function longint unsigned root(longint unsigned s);
         longint unsigned res = 0;
         longint unsigned b = 64'd1 << 62;
         while (b > s) b >>= 2;
         while (b != 0) begin
            if (s >= res + b) begin
               s -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      // Floors an integer quotient with a positive divisor.
      function longint fdiv(longint num, longint den);
         longint q = num / den;
         if ((num % den) != 0 && num < 0) q -= 1;
         return q;
      endfunction

      // Snaps toward zero to a multiple of the voxel size.
      function longint snap_corner(longint f, longint vs);
         longint mag = (f < 0) ? -f : f;
         if (mag <= vs) return 0;
         return f - (f % vs);
      endfunction

      // Notes an accepted edge and queues its expected corners.
      function void note_edge(req_type e);
         longint s[3], d[3], en[3];
         longint unsigned sumsq, len, n;
         longint vs, steps, f;
         rsp_type r;
         logic [15:0] cv[3];
         vs = (vox_size == 0) ? 1 : longint'(vox_size);
         s[0] = e.start_x; s[1] = e.start_y; s[2] = e.start_z;
         en[0] = e.end_x; en[1] = e.end_y; en[2] = e.end_z;
         sumsq = 0;
         for (int c = 0; c < 3; c++) begin
            d[c] = en[c] - s[c];
            sumsq += longint'(d[c] * d[c]);
         end
         len = root(sumsq);
         n = len / (longint'(vs) * 256);
         if (n > MAX_VOX) n = MAX_VOX;
         steps = 2 * longint'(n);
         for (longint k = 0; k < steps; k++) begin
            for (int c = 0; c < 3; c++) begin
               f = fdiv(s[c] * steps + k * d[c], steps * 256);
               cv[c] = 16'(snap_corner(f, vs));
            end
            r.corner_x = cv[0];
            r.corner_y = cv[1];
            r.corner_z = cv[2];
            r.last_corner = (k == steps - 1);
            pending_q = {pending_q, r};
         end
      endfunction

      // Compares one accepted corner with the oldest expected one.
      function void check_corner(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected corner %0d %0d %0d last %0b", got.corner_x,
                        got.corner_y, got.corner_z, got.last_corner);
            return;
         end
         want = pending_q.pop_front();
         if (got.corner_x !== want.corner_x || got.corner_y !== want.corner_y ||
             got.corner_z !== want.corner_z ||
             got.last_corner !== want.last_corner) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"corner mismatch: expected %0d %0d %0d last %0b,",
                         " got %0d %0d %0d last %0b"},
                        want.corner_x, want.corner_y, want.corner_z, want.last_corner,
                        got.corner_x, got.corner_y, got.corner_z, got.last_corner);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 0;
   logic [7:0] csr_wr_data = '0;

   corner_board board = new();
   int send_pct = 0;
   int recv_pct = 0;
   int hold_starts = 0;
   int hold_seen = 0;
   int hold_cycles = 0;
   bit timed_out = 0;

   edge_voxel_corner_stepper_unit #(.MAX_VOXELS_PER_EDGE(MAX_VOX)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Clock of 20 ns period.
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Result side: checks each transfer and picks the next stall. A long
   // hold-off requested by the stimulus is counted down here.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_corner(rsp_data);
         if (hold_seen != hold_starts) begin
            hold_seen   = hold_starts;
            hold_cycles = 1500;
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_pct);
         end
      end
   end

   // Offers one edge and waits for its transfer, then maybe idles.
   task automatic send_edge(req_type e);
      req_data  <= e;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      board.note_edge(e);
      if ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Waits until every expected corner has come, then lets the unit settle.
   task automatic drain();
      int guard = 0;
      req_valid <= 0;
      while (board.pending_q.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_voxel_size(logic [7:0] v);
      csr_wr_en   <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      board.vox_size = v;
   endtask

   function automatic req_type mk_edge(longint sx, longint sy, longint sz,
                                       longint ex, longint ey, longint ez);
      req_type e;
      e.start_x = 24'(sx); e.start_y = 24'(sy); e.start_z = 24'(sz);
      e.end_x = 24'(ex); e.end_y = 24'(ey); e.end_z = 24'(ez);
      return e;
   endfunction

   // Random edge: mostly within 38 voxels of the start on each axis, sometimes anything at all.
   function automatic req_type rand_edge();
      longint vs, r, sx, sy, sz;
      vs = (board.vox_size == 0) ? 1 : longint'(board.vox_size);
      if ($urandom_range(0, 99) < 15)
         return mk_edge($signed($urandom), $signed($urandom), $signed($urandom),
                        $signed($urandom), $signed($urandom), $signed($urandom));
      r = vs * 256 * $urandom_range(0, 38);
      sx = $signed(24'($urandom));
      sy = $signed(24'($urandom));
      sz = $signed(24'($urandom));
      if ($urandom_range(0, 1)) begin
         // Keep corners within the 16-bit output range most of the time.
         sx = sx >>> 8; sy = sy >>> 8; sz = sz >>> 8;
      end
      return mk_edge(sx, sy, sz,
                     sx + longint'($urandom_range(0, 32'(2 * r))) - r,
                     sy + longint'($urandom_range(0, 32'(2 * r))) - r,
                     sz + longint'($urandom_range(0, 32'(2 * r))) - r);
   endfunction

   task automatic random_phase(int count, int sp, int rp, bit pressure);
      send_pct = sp;
      recv_pct = rp;
      for (int i = 0; i < count; i++) begin
         if (pressure && i == 3) hold_starts++;
         send_edge(rand_edge());
      end
   endtask

   // Limit on the whole run.
   initial begin
      #30ms;
      timed_out = 1;
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus and final verdict.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_voxel_size(8'd1);

      // Directed edges at a voxel size of one.
      send_pct = 20;
      recv_pct = 20;
      send_edge(mk_edge(0, 0, 0, 0, 0, 0));
      send_edge(mk_edge(10, 20, 30, 10 + 255, 20, 30));
      send_edge(mk_edge(0, 0, 0, 256, 0, 0));
      send_edge(mk_edge(-300, -600, 700, -300 - 512, -600, 700 + 512));
      send_edge(mk_edge(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
      send_edge(mk_edge(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
      send_edge(mk_edge(-1, -257, 255, -1 + 2048, -257 - 2048, 255 + 1024));
      send_edge(mk_edge(8388607, -8388608, 0, 8388607 - 4096, -8388608 + 4096, 0));
      drain();

      // Voxel size of zero behaves as one.
      write_voxel_size(8'd0);
      send_edge(mk_edge(-700, 300, 0, -700 + 1024, 300, 0));
      send_edge(mk_edge(0, 0, 0, 100, 100, 100));
      drain();

      // Largest voxel size: thresholds and snapping toward zero.
      write_voxel_size(8'd255);
      send_edge(mk_edge(-65280 - 256, 65280, 0, -65280 - 256 + 65280 * 4, 65280, 0));
      send_edge(mk_edge(0, 0, 0, 65279, 0, 0));
      send_edge(mk_edge(200000, -200000, 65281, 200000, -200000 + 8388607, 65281));
      random_phase(20, 30, 55, 0);
      drain();

      write_voxel_size(8'($urandom_range(1, 255)));
      random_phase(30, 30, 55, 0);
      drain();

      write_voxel_size(8'd7);
      random_phase(40, 55, 30, 0);
      drain();

      write_voxel_size(8'd3);
      random_phase(25, 55, 30, 0);
      drain();

      write_voxel_size(8'd1);
      random_phase(40, 0, 0, 1);
      drain();

      if (!timed_out) begin
         if (board.mismatches == 0 && board.pending_q.size() == 0)
            $display("*** PASSED ***");
         else
            $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

FILE: sim.f
rtl/evcs_pkg.sv
rtl/edge_voxel_corner_stepper_unit.sv
rtl/evcs_checker.sv
tb/tb_edge_voxel_corner_stepper_unit.sv
